// ===== src/sbcrc_pkg.sv =====
// Shared constants, types and the byte-wide CRC-32 update of the superblock decoder.
package sbcrc_pkg;

    localparam int RECORD_BYTES = 64;
    localparam int CNT_W        = $clog2(RECORD_BYTES + 1);
    localparam int CRC_POS      = 32;
    localparam int WORD_COUNT   = 9;
    localparam int WORD_IDX_W   = $clog2(WORD_COUNT);
    localparam int FIELD_BYTES  = WORD_COUNT * 4;
    localparam int CFG_IDX_W    = 8;

    localparam logic [31:0] CRC_POLY = 32'hedb88320;
    localparam logic [31:0] CRC_ONES = 32'hffffffff;

    localparam logic [CFG_IDX_W-1:0] CFG_MAGIC        = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_VERSION      = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_DATA_START   = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SECTOR   = CFG_IDX_W'(3);

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_SHORT   = 3'd1,
        ST_CRC     = 3'd2,
        ST_MAGIC   = 3'd3,
        ST_VERSION = 3'd4,
        ST_GEOM    = 3'd5
    } status_t;

    // Record view after the current byte has been folded in.
    typedef struct packed {
        logic                            full;
        logic [31:0]                     crc;
        logic [WORD_COUNT-1:0][31:0]     words;
    } record_t;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        int          k;
        c = crc ^ {24'd0, b};
        for (k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ===== src/superblock_crc_decoder.sv =====
// Top level of the superblock record decoder with CRC-32 check.
//
// The s_ channel takes one record byte per item, with s_last on the final
// byte of the buffer. A reflected CRC-32 runs over the first RECORD_BYTES
// bytes, with the stored CRC word at offset 32 taken as zero, while the
// big-endian words at offsets 0 to 32 are captured. Bytes past RECORD_BYTES
// only matter for their last flag.
// The m_ channel carries one result item per record: status and the decoded
// fields, all zero for a short record. It appears in the cycle after the item
// with s_last is accepted. One byte is accepted every cycle while s_ready is
// high; the CRC step is a byte-wide update that completes in the accepting
// cycle, and the checks fill the result register. While a result waits and
// m_ready is low, s_ready is low; it returns high in the cycle m_ready rises.
// The cfg channel writes expected_magic, expected_version, data_start_sector
// and min_sector_size by index and is always ready; the user makes writes
// only while idle; the block does not enforce it. Reset clears the cfg
// registers and the byte counter, presets the CRC and drops m_valid.
module superblock_crc_decoder (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [sbcrc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                     cfg_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [7:0]                      s_data_byte,
    input  logic                            s_last,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [2:0]                      m_status,
    output logic [31:0]                     m_generation,
    output logic [31:0]                     m_sect_bytes,
    output logic [31:0]                     m_total_sects,
    output logic [31:0]                     m_log_first,
    output logic [31:0]                     m_log_last,
    output logic [31:0]                     m_record_flags,
    output logic [31:0]                     m_stored_crc
);
    import sbcrc_pkg::*;

    logic    take;
    record_t rec;

    assign cfg_ready = 1'b1;
    assign s_ready   = !m_valid || m_ready;
    assign take      = s_valid && s_ready;

    sbcrc_capture u_capture (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .take      (take),
        .data_byte (s_data_byte),
        .last      (s_last),
        .rec       (rec)
    );

    sbcrc_check u_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .take_last      (take && s_last),
        .rec            (rec),
        .m_ready        (m_ready),
        .m_valid        (m_valid),
        .m_status       (m_status),
        .m_generation   (m_generation),
        .m_sect_bytes   (m_sect_bytes),
        .m_total_sects  (m_total_sects),
        .m_log_first    (m_log_first),
        .m_log_last     (m_log_last),
        .m_record_flags (m_record_flags),
        .m_stored_crc   (m_stored_crc)
    );

endmodule

// ===== src/sbcrc_capture.sv =====
// Byte counter, running CRC and big-endian word capture for one record.
module sbcrc_capture (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 take,
    input  logic [7:0]           data_byte,
    input  logic                 last,
    output sbcrc_pkg::record_t   rec
);
    import sbcrc_pkg::*;

    logic [CNT_W-1:0]              count_reg, count_next;
    logic [31:0]                   crc_reg, crc_next;
    logic [WORD_COUNT-1:0][31:0]   words_reg, words_next;
    logic [WORD_IDX_W-1:0]         widx;
    logic                          in_window;

    assign widx      = count_reg[WORD_IDX_W+1:2];
    assign in_window = (count_reg >= CNT_W'(CRC_POS)) && (count_reg < CNT_W'(CRC_POS + 4));

    always_comb begin
        count_next = count_reg;
        crc_next   = crc_reg;
        words_next = words_reg;
        if (count_reg < CNT_W'(RECORD_BYTES)) begin
            count_next = count_reg + CNT_W'(1);
            crc_next   = crc_byte(crc_reg, in_window ? 8'd0 : data_byte);
            if (count_reg < CNT_W'(FIELD_BYTES)) begin
                words_next[widx] = {words_reg[widx][23:0], data_byte};
            end
        end
    end

    assign rec.full  = (count_next == CNT_W'(RECORD_BYTES));
    assign rec.crc   = crc_next ^ CRC_ONES;
    assign rec.words = words_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            crc_reg   <= CRC_ONES;
        end else if (take) begin
            if (last) begin
                count_reg <= '0;
                crc_reg   <= CRC_ONES;
            end else begin
                count_reg <= count_next;
                crc_reg   <= crc_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            words_reg <= words_next;
        end
    end

endmodule

// ===== src/sbcrc_check.sv =====
// Configuration registers, record checks and the registered result stage.
module sbcrc_check (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    input  logic [sbcrc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                     cfg_data,
    input  logic                            take_last,
    input  sbcrc_pkg::record_t              rec,
    input  logic                            m_ready,
    output logic                            m_valid,
    output logic [2:0]                      m_status,
    output logic [31:0]                     m_generation,
    output logic [31:0]                     m_sect_bytes,
    output logic [31:0]                     m_total_sects,
    output logic [31:0]                     m_log_first,
    output logic [31:0]                     m_log_last,
    output logic [31:0]                     m_record_flags,
    output logic [31:0]                     m_stored_crc
);
    import sbcrc_pkg::*;

    logic [31:0] magic_reg, version_reg, start_reg, min_size_reg;
    logic        valid_reg;
    status_t     status_reg, status_next;
    logic [WORD_COUNT-3:0][31:0] fields_reg, fields_next;
    logic        geom_ok;

    assign geom_ok = (rec.words[3] >= min_size_reg) &&
                     (rec.words[4] >= start_reg) &&
                     (rec.words[5] == start_reg) &&
                     (rec.words[6] >= rec.words[5]) &&
                     (rec.words[6] <= rec.words[4]);

    always_comb begin
        fields_next = rec.words[WORD_COUNT-1:2];
        if (!rec.full) begin
            status_next = ST_SHORT;
            fields_next = '0;
        end else if (rec.crc != rec.words[8]) begin
            status_next = ST_CRC;
        end else if (rec.words[0] != magic_reg) begin
            status_next = ST_MAGIC;
        end else if (rec.words[1] != version_reg) begin
            status_next = ST_VERSION;
        end else if (!geom_ok) begin
            status_next = ST_GEOM;
        end else begin
            status_next = ST_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            magic_reg    <= '0;
            version_reg  <= '0;
            start_reg    <= '0;
            min_size_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_MAGIC:      magic_reg    <= cfg_data;
                CFG_VERSION:    version_reg  <= cfg_data;
                CFG_DATA_START: start_reg    <= cfg_data;
                CFG_MIN_SECTOR: min_size_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (take_last) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (take_last) begin
            status_reg <= status_next;
            fields_reg <= fields_next;
        end
    end

    assign m_valid        = valid_reg;
    assign m_status       = status_reg;
    assign m_generation   = fields_reg[0];
    assign m_sect_bytes   = fields_reg[1];
    assign m_total_sects  = fields_reg[2];
    assign m_log_first    = fields_reg[3];
    assign m_log_last     = fields_reg[4];
    assign m_record_flags = fields_reg[5];
    assign m_stored_crc   = fields_reg[6];

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the superblock record decoder with CRC-32 check.
`timescale 1ns / 1ps

module testbench;
    import sbcrc_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int PHASE_BYTES  = 110;
    localparam int PHASE_RECS   = 2;

    localparam logic [3:0] FAULT_NONE    = 4'b0000;
    localparam logic [3:0] FAULT_CRC     = 4'b0001;
    localparam logic [3:0] FAULT_MAGIC   = 4'b0010;
    localparam logic [3:0] FAULT_VERSION = 4'b0100;
    localparam logic [3:0] FAULT_GEOM    = 4'b1000;

    typedef enum {FILL_GOOD, FILL_ZERO, FILL_ONES, FILL_NOISE} fill_e;

    typedef struct {
        status_t     status;
        logic [31:0] generation;
        logic [31:0] sect_bytes;
        logic [31:0] total_sects;
        logic [31:0] log_first;
        logic [31:0] log_last;
        logic [31:0] record_flags;
        logic [31:0] stored_crc;
    } sb_result_t;

    typedef struct {
        fill_e      fill;
        logic [3:0] faults;
        int         nbytes;
        bit         typed;
        status_t    status;
    } stim_row_t;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [31:0]          cfg_data;
    logic                 s_valid;
    logic                 s_ready;
    logic [7:0]           s_data_byte;
    logic                 s_last;
    logic                 m_valid;
    logic                 m_ready;
    logic [2:0]           m_status;
    logic [31:0]          m_generation;
    logic [31:0]          m_sect_bytes;
    logic [31:0]          m_total_sects;
    logic [31:0]          m_log_first;
    logic [31:0]          m_log_last;
    logic [31:0]          m_record_flags;
    logic [31:0]          m_stored_crc;

    logic [31:0] cfg_magic      = '0;
    logic [31:0] cfg_version    = '0;
    logic [31:0] cfg_data_start = '0;
    logic [31:0] cfg_min_sector = '0;

    int unsigned rec_count = 0;
    logic [31:0] run_crc   = CRC_ONES;
    logic [31:0] cap_words [WORD_COUNT] = '{default: '0};

    logic [7:0]  rec_img [RECORD_BYTES];
    sb_result_t  pending_results [$];
    int unsigned mismatch_count  = 0;
    int unsigned cycle_count     = 0;
    int          send_idle_pct   = 0;
    int          recv_stall_pct  = 0;

    stim_row_t directed_rows [16] = '{
        '{FILL_GOOD,  FAULT_NONE,    RECORD_BYTES,      1'b1, ST_OK},
        '{FILL_ZERO,  FAULT_NONE,    1,                 1'b1, ST_SHORT},
        '{FILL_ONES,  FAULT_NONE,    RECORD_BYTES - 1,  1'b1, ST_SHORT},
        '{FILL_GOOD,  FAULT_NONE,    36,                1'b1, ST_SHORT},
        '{FILL_ZERO,  FAULT_NONE,    RECORD_BYTES,      1'b0, ST_OK},
        '{FILL_ONES,  FAULT_NONE,    RECORD_BYTES,      1'b0, ST_OK},
        '{FILL_GOOD,  FAULT_CRC,     RECORD_BYTES,      1'b1, ST_CRC},
        '{FILL_GOOD,  FAULT_MAGIC,   RECORD_BYTES,      1'b1, ST_MAGIC},
        '{FILL_GOOD,  FAULT_VERSION, RECORD_BYTES,      1'b1, ST_VERSION},
        '{FILL_GOOD,  FAULT_GEOM,    RECORD_BYTES,      1'b1, ST_GEOM},
        '{FILL_GOOD,  FAULT_CRC | FAULT_MAGIC | FAULT_VERSION | FAULT_GEOM,
                                     RECORD_BYTES,      1'b1, ST_CRC},
        '{FILL_GOOD,  FAULT_MAGIC | FAULT_VERSION | FAULT_GEOM,
                                     RECORD_BYTES,      1'b1, ST_MAGIC},
        '{FILL_GOOD,  FAULT_VERSION | FAULT_GEOM,
                                     RECORD_BYTES,      1'b1, ST_VERSION},
        '{FILL_GOOD,  FAULT_NONE,    RECORD_BYTES + 1,  1'b1, ST_OK},
        '{FILL_GOOD,  FAULT_GEOM,    RECORD_BYTES + 66, 1'b1, ST_GEOM},
        '{FILL_NOISE, FAULT_NONE,    RECORD_BYTES,      1'b0, ST_OK}
    };

    superblock_crc_decoder u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data_byte    (s_data_byte),
        .s_last         (s_last),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_generation   (m_generation),
        .m_sect_bytes   (m_sect_bytes),
        .m_total_sects  (m_total_sects),
        .m_log_first    (m_log_first),
        .m_log_last     (m_log_last),
        .m_record_flags (m_record_flags),
        .m_stored_crc   (m_stored_crc)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic logic [31:0] crc_step(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        int          k;
        r = c ^ 32'(b);
        for (k = 0; k < 8; k++) begin
            r = (r >> 1) ^ (r[0] ? CRC_POLY : 32'h0);
        end
        return r;
    endfunction

    // Folds one accepted byte into the record state; returns 1 when it closes a record.
    function automatic bit decode_byte(input logic [7:0] b, input bit is_last,
                                       output sb_result_t r);
        int unsigned off;
        bit          geom_ok;
        r = '{ST_OK, '0, '0, '0, '0, '0, '0, '0};
        if (rec_count < RECORD_BYTES) begin
            off = rec_count;
            run_crc = crc_step(run_crc,
                (off >= CRC_POS && off < CRC_POS + 4) ? 8'h00 : b);
            if (off < WORD_COUNT * 4) begin
                cap_words[off / 4] = {cap_words[off / 4][23:0], b};
            end
            rec_count = off + 1;
        end
        if (!is_last) begin
            return 1'b0;
        end
        if (rec_count < RECORD_BYTES) begin
            r.status = ST_SHORT;
        end else begin
            geom_ok = cap_words[3] >= cfg_min_sector && cap_words[4] >= cfg_data_start &&
                      cap_words[5] == cfg_data_start && cap_words[6] >= cap_words[5] &&
                      cap_words[6] <= cap_words[4];
            if (~run_crc != cap_words[8]) r.status = ST_CRC;
            else if (cap_words[0] != cfg_magic) r.status = ST_MAGIC;
            else if (cap_words[1] != cfg_version) r.status = ST_VERSION;
            else if (!geom_ok) r.status = ST_GEOM;
            else r.status = ST_OK;
            r.generation   = cap_words[2];
            r.sect_bytes   = cap_words[3];
            r.total_sects  = cap_words[4];
            r.log_first    = cap_words[5];
            r.log_last     = cap_words[6];
            r.record_flags = cap_words[7];
            r.stored_crc   = cap_words[8];
        end
        rec_count = 0;
        run_crc   = CRC_ONES;
        return 1'b1;
    endfunction

    // Fills rec_img with one record that fits the current register settings for
    // FILL_GOOD, then breaks the checks selected by faults; other fills use neither.
    function automatic void build_record(input fill_e fill, input logic [3:0] faults);
        logic [31:0]     w [WORD_COUNT];
        logic [31:0]     c;
        longint unsigned span;
        int              i;
        case (fill)
            FILL_ZERO: begin
                for (i = 0; i < RECORD_BYTES; i++) rec_img[i] = 8'h00;
            end
            FILL_ONES: begin
                for (i = 0; i < RECORD_BYTES; i++) rec_img[i] = 8'hff;
            end
            FILL_NOISE: begin
                for (i = 0; i < RECORD_BYTES; i++) rec_img[i] = 8'($urandom);
            end
            default: begin
                w[0] = cfg_magic;
                w[1] = cfg_version;
                w[2] = $urandom;
                w[3] = $urandom;
                if (w[3] < cfg_min_sector) w[3] = cfg_min_sector;
                w[4] = $urandom;
                if (w[4] < cfg_data_start) w[4] = cfg_data_start;
                w[5] = cfg_data_start;
                span = 64'(w[4]) - 64'(w[5]) + 64'd1;
                w[6] = 32'(64'(w[5]) + 64'($urandom) % span);
                w[7] = $urandom;
                w[8] = '0;
                if ((faults & FAULT_MAGIC) != 0) w[0] ^= $urandom | 32'h1;
                if ((faults & FAULT_VERSION) != 0) w[1] ^= $urandom | 32'h1;
                if ((faults & FAULT_GEOM) != 0) begin
                    case ($urandom_range(0, 4))
                        0: begin
                            if (cfg_min_sector != 0) w[3] = $urandom % cfg_min_sector;
                            else w[5] ^= 32'h1 << $urandom_range(0, 31);
                        end
                        1: begin
                            if (cfg_data_start != 0) w[4] = $urandom % cfg_data_start;
                            else w[5] ^= 32'h1 << $urandom_range(0, 31);
                        end
                        3: begin
                            if (cfg_data_start != 0) w[6] = $urandom % cfg_data_start;
                            else w[5] ^= 32'h1 << $urandom_range(0, 31);
                        end
                        4: begin
                            if (w[4] != '1) w[6] = w[4] + 32'd1 + ($urandom % ~w[4]);
                            else w[5] ^= 32'h1 << $urandom_range(0, 31);
                        end
                        default: w[5] ^= 32'h1 << $urandom_range(0, 31);
                    endcase
                end
                for (i = 0; i < CRC_POS; i++) begin
                    rec_img[i] = 8'(w[i / 4] >> (24 - 8 * (i % 4)));
                end
                for (i = CRC_POS + 4; i < RECORD_BYTES; i++) rec_img[i] = 8'($urandom);
                c = CRC_ONES;
                for (i = 0; i < RECORD_BYTES; i++) begin
                    c = crc_step(c,
                        (i >= CRC_POS && i < CRC_POS + 4) ? 8'h00 : rec_img[i]);
                end
                c = ~c;
                if ((faults & FAULT_CRC) != 0) c ^= 32'h1 << $urandom_range(0, 31);
                for (i = 0; i < 4; i++) rec_img[CRC_POS + i] = 8'(c >> (24 - 8 * i));
            end
        endcase
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %h, got %h", name, want, got);
            mismatch_count++;
        end
    endfunction

    task automatic send_byte(input logic [7:0] b, input bit is_last, input bit typed,
                             input status_t typed_status);
        sb_result_t r;
        s_valid     <= 1'b1;
        s_data_byte <= b;
        s_last      <= is_last;
        do @(posedge aclk); while (!s_ready);
        if (decode_byte(b, is_last, r)) begin
            if (typed) begin
                r.status = typed_status;
                if (typed_status == ST_SHORT) begin
                    r = '{ST_SHORT, '0, '0, '0, '0, '0, '0, '0};
                end
            end
            pending_results.push_back(r);
        end
        if ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < send_idle_pct);
        end
    endtask

    task automatic send_record(input fill_e fill, input logic [3:0] faults, input int nbytes,
                               input bit typed, input status_t typed_status);
        int         i;
        logic [7:0] b;
        build_record(fill, faults);
        for (i = 0; i < nbytes; i++) begin
            b = (i < RECORD_BYTES) ? rec_img[i] : 8'($urandom);
            send_byte(b, i == nbytes - 1, typed, typed_status);
        end
    endtask

    // The last write goes to an unused index and must leave every register alone.
    task automatic write_regs(input logic [31:0] magic, input logic [31:0] version,
                              input logic [31:0] data_start, input logic [31:0] min_sector);
        logic [CFG_IDX_W-1:0] idx [5];
        logic [31:0]          val [5];
        int                   i;
        idx[0] = CFG_MAGIC;      val[0] = magic;
        idx[1] = CFG_VERSION;    val[1] = version;
        idx[2] = CFG_DATA_START; val[2] = data_start;
        idx[3] = CFG_MIN_SECTOR; val[3] = min_sector;
        idx[4] = CFG_IDX_W'($urandom_range(4, 255));
        val[4] = $urandom;
        for (i = 0; i < 5; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            do @(posedge aclk); while (!cfg_ready);
            case (idx[i])
                CFG_MAGIC:      cfg_magic      = val[i];
                CFG_VERSION:    cfg_version    = val[i];
                CFG_DATA_START: cfg_data_start = val[i];
                CFG_MIN_SECTOR: cfg_min_sector = val[i];
                default: ;
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_for_results();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic run_random(input int idle_pct, input int stall_pct);
        int         bytes_sent;
        int         recs;
        int         pick;
        int         n;
        logic [3:0] faults;
        fill_e      fill;
        bytes_sent     = 0;
        recs           = 0;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        while (bytes_sent < PHASE_BYTES || recs < PHASE_RECS) begin
            pick   = $urandom_range(0, 99);
            fill   = FILL_GOOD;
            faults = FAULT_NONE;
            n      = RECORD_BYTES;
            if (pick < 55) begin
                faults = FAULT_NONE;
            end else if (pick < 78) begin
                if ($urandom_range(0, 3) == 0) faults = 4'($urandom_range(1, 15));
                else faults = FAULT_CRC << $urandom_range(0, 3);
            end else if (pick < 90) begin
                n = $urandom_range(1, RECORD_BYTES - 1);
            end else begin
                fill = FILL_NOISE;
                if ($urandom_range(0, 1) == 1) n = $urandom_range(1, RECORD_BYTES - 1);
            end
            if (n == RECORD_BYTES && $urandom_range(0, 7) == 0) n += $urandom_range(1, 40);
            send_record(fill, faults, n, 1'b0, ST_OK);
            bytes_sent += n;
            recs++;
        end
        wait_for_results();
    endtask

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        sb_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("result item arrived with no expectation pending");
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("status", 32'(want.status), 32'(m_status));
                check_field("generation", want.generation, m_generation);
                check_field("sect_bytes", want.sect_bytes, m_sect_bytes);
                check_field("total_sects", want.total_sects, m_total_sects);
                check_field("log_first", want.log_first, m_log_first);
                check_field("log_last", want.log_last, m_log_last);
                check_field("record_flags", want.record_flags, m_record_flags);
                check_field("stored_crc", want.stored_crc, m_stored_crc);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("superblock_crc_decoder test failed");
            $finish;
        end
    end

    initial begin
        int row;
        aresetn     = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        s_valid     = 1'b0;
        s_data_byte = '0;
        s_last      = 1'b0;
        m_ready     = 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed records run with the registers at their reset values.
        for (row = 0; row < 16; row++) begin
            send_record(directed_rows[row].fill, directed_rows[row].faults,
                        directed_rows[row].nbytes, directed_rows[row].typed,
                        directed_rows[row].status);
        end
        wait_for_results();

        write_regs($urandom, $urandom, $urandom, $urandom);
        run_random(0, 0);
        write_regs('1, '1, '1, '1);
        run_random(46, 0);
        write_regs('0, '0, '0, '0);
        run_random(0, 46);
        write_regs($urandom, $urandom_range(0, 15), $urandom_range(0, 4096),
                   $urandom_range(512, 4096));
        run_random(22, 22);

        if (mismatch_count == 0) begin
            $display("superblock_crc_decoder test passed");
        end else begin
            $display("superblock_crc_decoder test failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/sbcrc_pkg.sv
src/sbcrc_capture.sv
src/sbcrc_check.sv
src/superblock_crc_decoder.sv
tb/testbench.sv
